[rtl/fla_pkg.sv]
package fla_pkg;

	localparam int unsigned HeapUnits = 1024;
	localparam int unsigned UnitBytes = 16;
	localparam int unsigned AddrW = $clog2(HeapUnits);
	localparam int unsigned SizeW = AddrW + 1;
	localparam int unsigned UnitShift = $clog2(UnitBytes);
	localparam int unsigned CntW = AddrW + 1;
	localparam logic [CntW-1:0] WalkLast = CntW'(HeapUnits);

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_DONATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_TOO_SMALL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [AddrW-1:0] addr;
		logic [14:0]      nbytes;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [AddrW-1:0] result_addr;
	} rsp_t;

	typedef struct packed {
		logic [AddrW-1:0] next;
		logic [SizeW-1:0] size;
	} hdr_t;

	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] addr;
		hdr_t             data;
	} hdr_wr_t;

endpackage

[rtl/fla_hdr_store.sv]
module fla_hdr_store (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [fla_pkg::AddrW-1:0] rd_addr,
	input  fla_pkg::hdr_wr_t         wr,
	output fla_pkg::hdr_t            rd_data
);

	fla_pkg::hdr_t mem_q [fla_pkg::HeapUnits];
	fla_pkg::hdr_t raw_q;
	logic sentinel_written_q;
	logic rd_zero_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		raw_q <= mem_q[rd_addr];
	end

	// Entry 0 reads as the self-linked empty sentinel until it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentinel_written_q <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			rd_zero_q <= (rd_addr == '0);
			if (wr.we && wr.addr == '0) begin
				sentinel_written_q <= 1'b1;
			end
		end
	end

	assign rd_data = (rd_zero_q && !sentinel_written_q) ? '0 : raw_q;

endmodule

[rtl/free_list_heap_allocator.sv]
// Free-list heap allocator over 1024 sixteen-byte units, with the free blocks kept
// in a circular, address-ordered list whose headers live in an on-chip store.
// A request is taken when start is high and busy is low. A request that needs a
// walk raises busy in the next cycle and drops it in the cycle in which its single
// response appears, marked by a one-cycle done strobe. A request that is rejected
// or ignored at once answers in the next cycle without raising busy.
// The receiver cannot stall that response, so it must capture it when done is high.
// A request that needs a walk reads one free-list header per cycle through the
// single read port of the header store, and a walk never exceeds 1025 links. An
// allocate reads the rover's header, then checks blocks until one fits, splitting
// a larger one in a last step. A free first reads the freed block's header; free
// and donate walk to the insertion point and write the new and the prior header.
// No clearing pass is needed after reset; unit 0 is the empty sentinel.
module free_list_heap_allocator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  fla_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output fla_pkg::rsp_t rsp
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_APREV  = 10'b00_0000_0010,
		S_ACHK   = 10'b00_0000_0100,
		S_ACARVE = 10'b00_0000_1000,
		S_IBP    = 10'b00_0001_0000,
		S_IWALK  = 10'b00_0010_0000,
		S_IREREAD= 10'b00_0100_0000,
		S_INX    = 10'b00_1000_0000,
		S_IPW    = 10'b01_0000_0000,
		S_SPARE  = 10'b10_0000_0000
	} state_t;

	localparam int unsigned AW = fla_pkg::AddrW;
	localparam int unsigned SW = fla_pkg::SizeW;

	state_t state_q, state_d;
	logic [AW-1:0] rover_q, rover_d;
	logic [AW-1:0] p_q, p_d;
	logic [AW-1:0] prev_q, prev_d;
	logic [AW-1:0] bp_q, bp_d;
	logic [AW-1:0] nx_q, nx_d;
	logic [AW-1:0] q_q, q_d;
	logic [SW-1:0] need_q, need_d;
	logic [SW-1:0] bp_size_q, bp_size_d;
	fla_pkg::hdr_t prev_e_q, prev_e_d;
	fla_pkg::hdr_t p_e_q, p_e_d;
	fla_pkg::hdr_t bpn_q, bpn_d;
	logic [fla_pkg::CntW-1:0] cnt_q, cnt_d;
	fla_pkg::rsp_t rsp_q, rsp_d;
	logic done_q, done_d;

	logic [AW-1:0] rd_addr;
	fla_pkg::hdr_wr_t wr;
	fla_pkg::hdr_t rdata;

	fla_hdr_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_data (rdata)
	);

	// Request decode helpers.
	logic [15:0] bytes_up;
	logic [SW:0]   units_raw;
	logic [SW-1:0] req_units;
	logic [SW-1:0] don_size;
	logic [SW-1:0] don_room;
	assign bytes_up  = {1'b0, req.nbytes} + 16'(fla_pkg::UnitBytes - 1);
	assign units_raw = (SW+1)'(bytes_up >> fla_pkg::UnitShift) + (SW+1)'(1);
	// Huge requests saturate; no block can ever be that large, so they still fail.
	assign req_units = units_raw[SW] ? '1 : units_raw[SW-1:0];
	assign don_size  = SW'(req.nbytes >> fla_pkg::UnitShift);
	assign don_room  = SW'(fla_pkg::HeapUnits) - {1'b0, req.addr};

	// Walk and merge arithmetic.
	logic [SW-1:0] carve_size;
	logic [SW:0]   carve_end;
	logic          ins_here;
	logic [SW:0]   bp_end;
	logic [SW:0]   p_end;
	fla_pkg::hdr_t pe_now;
	assign carve_size = rdata.size - need_q;
	assign carve_end  = {1'b0, {1'b0, p_q} + carve_size};
	assign ins_here   = (bp_q > p_q && bp_q < rdata.next) ||
	                    (p_q >= rdata.next && (bp_q > p_q || bp_q < rdata.next));
	assign bp_end     = (SW+1)'(bp_q) + (SW+1)'(bp_size_q);
	assign pe_now     = (p_q == bp_q) ? bpn_q : p_e_q;
	assign p_end      = (SW+1)'(p_q) + (SW+1)'(pe_now.size);

	always_comb begin
		state_d   = state_q;
		rover_d   = rover_q;
		p_d       = p_q;
		prev_d    = prev_q;
		bp_d      = bp_q;
		nx_d      = nx_q;
		q_d       = q_q;
		need_d    = need_q;
		bp_size_d = bp_size_q;
		prev_e_d  = prev_e_q;
		p_e_d     = p_e_q;
		bpn_d     = bpn_q;
		cnt_d     = cnt_q;
		rsp_d     = rsp_q;
		done_d    = 1'b0;
		rd_addr   = rover_q;
		wr        = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					rsp_d = '{status: fla_pkg::ST_DONE, result_addr: '0};
					unique case (fla_pkg::cmd_t'(req.cmd))
						fla_pkg::CMD_ALLOC: begin
							need_d  = req_units;
							state_d = S_APREV;
						end
						fla_pkg::CMD_FREE: begin
							if (req.addr >= AW'(2)) begin
								bp_d    = req.addr - AW'(1);
								rd_addr = req.addr - AW'(1);
								state_d = S_IBP;
							end else begin
								done_d = 1'b1;
							end
						end
						fla_pkg::CMD_DONATE: begin
							if (req.nbytes < 15'(fla_pkg::UnitBytes) || req.addr == '0) begin
								rsp_d.status = fla_pkg::ST_TOO_SMALL;
								done_d       = 1'b1;
							end else begin
								bp_d      = req.addr;
								bp_size_d = (don_size > don_room) ? don_room : don_size;
								p_d       = rover_q;
								cnt_d     = '0;
								state_d   = S_IWALK;
							end
						end
						fla_pkg::CMD_NONE: begin
							done_d = 1'b1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_APREV: begin
				prev_d   = rover_q;
				prev_e_d = rdata;
				p_d      = rdata.next;
				rd_addr  = rdata.next;
				cnt_d    = '0;
				state_d  = S_ACHK;
			end
			S_ACHK: begin
				rd_addr = rdata.next;
				if (rdata.size >= need_q) begin
					if (rdata.size == need_q) begin
						wr = '{we: 1'b1, addr: prev_q,
						       data: '{next: rdata.next, size: prev_e_q.size}};
						rover_d = prev_q;
						rsp_d.result_addr = p_q + AW'(1);
						done_d  = 1'b1;
						state_d = S_IDLE;
					end else begin
						wr = '{we: 1'b1, addr: p_q,
						       data: '{next: rdata.next, size: carve_size}};
						q_d     = carve_end[AW-1:0];
						rd_addr = carve_end[AW-1:0];
						state_d = S_ACARVE;
					end
				end else if (p_q == rover_q || cnt_q == fla_pkg::WalkLast) begin
					rsp_d.status = fla_pkg::ST_NO_FIT;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					prev_d   = p_q;
					prev_e_d = rdata;
					p_d      = rdata.next;
					cnt_d    = cnt_q + 1'b1;
				end
			end
			S_ACARVE: begin
				wr = '{we: 1'b1, addr: q_q, data: '{next: rdata.next, size: need_q}};
				rover_d = prev_q;
				rsp_d.result_addr = q_q + AW'(1);
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_IBP: begin
				bp_size_d = rdata.size;
				p_d       = rover_q;
				cnt_d     = '0;
				state_d   = S_IWALK;
			end
			S_IWALK: begin
				// The read of p was issued in the previous cycle.
				rd_addr = rdata.next;
				p_e_d   = rdata;
				nx_d    = rdata.next;
				if (ins_here) begin
					state_d = S_INX;
				end else if (cnt_q == fla_pkg::WalkLast) begin
					p_d     = rdata.next;
					state_d = S_IREREAD;
				end else begin
					p_d   = rdata.next;
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_IREREAD: begin
				p_e_d   = rdata;
				nx_d    = rdata.next;
				rd_addr = rdata.next;
				state_d = S_INX;
			end
			S_INX: begin
				if (bp_end == (SW+1)'(nx_q)) begin
					bpn_d = '{next: rdata.next, size: bp_size_q + rdata.size};
				end else begin
					bpn_d = '{next: nx_q, size: bp_size_q};
				end
				wr = '{we: 1'b1, addr: bp_q, data: bpn_d};
				state_d = S_IPW;
			end
			S_IPW: begin
				if (p_end == (SW+1)'(bp_q)) begin
					wr = '{we: 1'b1, addr: p_q,
					       data: '{next: bpn_q.next, size: pe_now.size + bpn_q.size}};
				end else begin
					wr = '{we: 1'b1, addr: p_q, data: '{next: bp_q, size: pe_now.size}};
				end
				rover_d = p_q;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Read the rover's header first for an allocate and for each insert walk.
		if (state_q == S_IDLE && start && fla_pkg::cmd_t'(req.cmd) == fla_pkg::CMD_DONATE) begin
			rd_addr = rover_q;
		end
		if (state_q == S_IBP) begin
			rd_addr = rover_q;
		end
		if (state_q == S_IDLE && start && fla_pkg::cmd_t'(req.cmd) == fla_pkg::CMD_ALLOC) begin
			rd_addr = rover_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rover_q <= '0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			rover_q <= rover_d;
			done_q  <= done_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q       <= p_d;
		prev_q    <= prev_d;
		bp_q      <= bp_d;
		nx_q      <= nx_d;
		q_q       <= q_d;
		need_q    <= need_d;
		bp_size_q <= bp_size_d;
		prev_e_q  <= prev_e_d;
		p_e_q     <= p_e_d;
		bpn_q     <= bpn_d;
		rsp_q     <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// A response follows only a cycle in which a request was taken or being worked.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("response without a request");

	// The walk counter never runs past its limit.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fla_pkg::WalkLast)
		else $error("walk counter overran");

	// A failed allocation or donation never reports an address.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != fla_pkg::ST_DONE) |-> rsp.result_addr == '0)
		else $error("address reported on failure");

	// No second response while the block stays idle without a new request.
	a_single_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !start && !busy) |=> !done)
		else $error("repeated response");

endmodule

[tb/free_list_heap_allocator_test.sv]
module free_list_heap_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Clock, reset and the request/response ports of the allocator. Every input
	// starts at a known value so that nothing floats before the first edge.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	fla_pkg::req_t req = '0;
	logic busy;
	logic done;
	fla_pkg::rsp_t rsp;

	free_list_heap_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Requests waiting to be driven, and the response each one must produce.
	fla_pkg::req_t pending_reqs[$];
	fla_pkg::rsp_t expected_rsps[$];
	int errors = 0;

	// Our own copy of the free list: the header of every unit (link and size
	// in units) plus the rover where the next-fit walk begins.
	logic [fla_pkg::AddrW-1:0] link_of[fla_pkg::HeapUnits];
	logic [fla_pkg::SizeW-1:0] units_of[fla_pkg::HeapUnits];
	int rover_at;

	// Bookkeeping used only to keep the request stream legal: which units were
	// ever handed to the heap (a new donation must not overlap them) and which
	// payloads are currently allocated and therefore safe to free.
	bit donated[fla_pkg::HeapUnits];
	int live_payloads[$];

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Links the block whose header sits at unit bp into the address-ordered
	// ring, merging it with the block right after it and the one right before.
	function automatic void link_block(input int bp);
		int p;
		int nx;
		p = rover_at;
		for (int steps = 0; steps < fla_pkg::HeapUnits + 1; steps++) begin
			nx = int'(link_of[p]);
			if (bp > p && bp < nx)
				break;
			if (p >= nx && (bp > p || bp < nx))
				break;
			p = nx;
		end
		nx = int'(link_of[p]);
		if (bp + int'(units_of[bp]) == nx) begin
			units_of[bp] = units_of[bp] + units_of[nx];
			link_of[bp] = link_of[nx];
		end else begin
			link_of[bp] = fla_pkg::AddrW'(nx);
		end
		if (p + int'(units_of[p]) == bp) begin
			units_of[p] = units_of[p] + units_of[bp];
			link_of[p] = link_of[bp];
		end else begin
			link_of[p] = fla_pkg::AddrW'(bp);
		end
		rover_at = p;
	endfunction

	// Next-fit search from the rover. An exact fit leaves the ring whole; a
	// larger block keeps its front and gives its tail away. Fails after one lap.
	function automatic bit carve_block(input int nbytes, output int payload);
		int need;
		int prev;
		int p;
		need = (nbytes + fla_pkg::UnitBytes - 1) / fla_pkg::UnitBytes + 1;
		prev = rover_at;
		p = int'(link_of[prev]);
		payload = 0;
		for (int steps = 0; steps < fla_pkg::HeapUnits + 1; steps++) begin
			if (int'(units_of[p]) >= need) begin
				if (int'(units_of[p]) == need) begin
					link_of[prev] = link_of[p];
				end else begin
					units_of[p] = fla_pkg::SizeW'(int'(units_of[p]) - need);
					p = (p + int'(units_of[p])) % fla_pkg::HeapUnits;
					units_of[p] = fla_pkg::SizeW'(need);
				end
				rover_at = prev;
				payload = p + 1;
				return 1'b1;
			end
			if (p == rover_at)
				return 1'b0;
			prev = p;
			p = int'(link_of[p]);
		end
		return 1'b0;
	endfunction

	// Works out the response of one request, updates the free-list copy and
	// queues the request together with its expected response.
	task automatic issue(input fla_pkg::cmd_t cmd, input int addr, input int nbytes);
		fla_pkg::rsp_t want;
		int payload;
		int span;
		want = '{status: fla_pkg::ST_DONE, result_addr: '0};
		case (cmd)
			fla_pkg::CMD_ALLOC: begin
				if (carve_block(nbytes, payload)) begin
					want.result_addr = fla_pkg::AddrW'(payload);
					// A payload one past the heap end cannot be named by a free.
					if (payload < fla_pkg::HeapUnits)
						live_payloads.push_back(payload);
				end else begin
					want.status = fla_pkg::ST_NO_FIT;
				end
			end
			fla_pkg::CMD_FREE: begin
				if (addr >= 2)
					link_block(addr - 1);
			end
			fla_pkg::CMD_DONATE: begin
				if (nbytes < fla_pkg::UnitBytes || addr == 0) begin
					want.status = fla_pkg::ST_TOO_SMALL;
				end else begin
					span = nbytes / fla_pkg::UnitBytes;
					if (span > fla_pkg::HeapUnits - addr)
						span = fla_pkg::HeapUnits - addr;
					for (int u = addr; u < addr + span; u++)
						donated[u] = 1'b1;
					units_of[addr] = fla_pkg::SizeW'(span);
					link_block(addr);
				end
			end
			default: ;
		endcase
		pending_reqs.push_back(fla_pkg::req_t'{cmd: cmd, addr: fla_pkg::AddrW'(addr),
			nbytes: 15'(nbytes)});
		expected_rsps.push_back(want);
	endtask

	// Frees a randomly chosen live allocation; falls back to an allocate.
	task automatic free_some_block();
		int k;
		if (live_payloads.size() == 0) begin
			issue(fla_pkg::CMD_ALLOC, 0, $urandom_range(0, 120));
		end else begin
			k = $urandom_range(0, live_payloads.size() - 1);
			issue(fla_pkg::CMD_FREE, live_payloads[k], 0);
			live_payloads.delete(k);
		end
	endtask

	// Donates never-donated units from a random start point, the length kept
	// inside the untouched run there; a run that reaches the heap end may be
	// overshot to exercise clipping. A donated start gets a too-small donation.
	task automatic donate_fresh_region();
		int at;
		int run;
		int max_bytes;
		at = $urandom_range(1, fla_pkg::HeapUnits - 1);
		if (donated[at]) begin
			issue(fla_pkg::CMD_DONATE, $urandom_range(0, fla_pkg::HeapUnits - 1),
				$urandom_range(0, fla_pkg::UnitBytes - 1));
			return;
		end
		run = 0;
		while (at + run < fla_pkg::HeapUnits && !donated[at + run])
			run++;
		if (at + run == fla_pkg::HeapUnits && $urandom_range(0, 3) == 0) begin
			max_bytes = 32767;
		end else begin
			max_bytes = run * fla_pkg::UnitBytes + fla_pkg::UnitBytes - 1;
			if (max_bytes > 32767)
				max_bytes = 32767;
			if ($urandom_range(0, 3) != 0 && max_bytes > 40 * fla_pkg::UnitBytes)
				max_bytes = 40 * fla_pkg::UnitBytes;
		end
		issue(fla_pkg::CMD_DONATE, at, $urandom_range(fla_pkg::UnitBytes, max_bytes));
	endtask

	// Request driver. A new request is put up once the previous one has been
	// taken (start high while busy is low), after an optional random gap.
	int gap_left = 0;
	bit steady_run = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_reqs.size() != 0) begin
				start <= 1'b1;
				req <= pending_reqs.pop_front();
				if ($urandom_range(0, 99) == 0)
					steady_run = ~steady_run;
				if (steady_run || $urandom_range(0, 2) == 0)
					gap_left <= 0;
				else if ($urandom_range(0, 9) == 0)
					gap_left <= $urandom_range(10, 60);
				else
					gap_left <= $urandom_range(1, 3);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Response monitor. The response is shown for one cycle only, so it is
	// taken at the edge where done is high and compared with the oldest
	// expectation field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				report($sformatf("unexpected response status %0d addr %0d",
					rsp.status, rsp.result_addr));
			end else begin
				if (rsp.status !== expected_rsps[0].status)
					report($sformatf("status %0d, expected %0d",
						rsp.status, expected_rsps[0].status));
				if (rsp.result_addr !== expected_rsps[0].result_addr)
					report($sformatf("result_addr %0d, expected %0d",
						rsp.result_addr, expected_rsps[0].result_addr));
				void'(expected_rsps.pop_front());
			end
		end
	end

	initial begin
		int pick;
		for (int u = 0; u < fla_pkg::HeapUnits; u++) begin
			link_of[u] = '0;
			units_of[u] = '0;
			donated[u] = 1'b0;
		end
		donated[0] = 1'b1;
		rover_at = 0;

		// Directed part. The heap starts empty, so the first allocate fails.
		// Then come the ignored frees (units 0 and 1), donations that are too
		// small or start at the sentinel, and the unused command.
		issue(fla_pkg::CMD_ALLOC, 0, 0);
		issue(fla_pkg::CMD_FREE, 0, 0);
		issue(fla_pkg::CMD_FREE, 1, 0);
		issue(fla_pkg::CMD_DONATE, 100, fla_pkg::UnitBytes - 1);
		issue(fla_pkg::CMD_DONATE, 0, 16384);
		issue(fla_pkg::CMD_NONE, 1023, 32767);
		// A donation that runs far past the heap end is clipped to four units.
		// A zero-byte allocate needs just the header unit; it is carved from
		// the tail, so its payload lies one past the heap end and reads as 0.
		issue(fla_pkg::CMD_DONATE, 1020, 16384);
		issue(fla_pkg::CMD_ALLOC, 0, 0);
		// Neighboring donations that merge on both sides, plus a one-unit block
		// at unit 1 that merges into the front of the large block.
		issue(fla_pkg::CMD_DONATE, 2, 500 * fla_pkg::UnitBytes);
		issue(fla_pkg::CMD_DONATE, 600, 100 * fla_pkg::UnitBytes + fla_pkg::UnitBytes - 1);
		issue(fla_pkg::CMD_DONATE, 502, 98 * fla_pkg::UnitBytes);
		issue(fla_pkg::CMD_DONATE, 1, fla_pkg::UnitBytes);
		issue(fla_pkg::CMD_ALLOC, 32767, 0);
		issue(fla_pkg::CMD_ALLOC, 0, 0);
		issue(fla_pkg::CMD_ALLOC, 0, 1);
		issue(fla_pkg::CMD_ALLOC, 0, 16);
		issue(fla_pkg::CMD_ALLOC, 1023, 17);
		issue(fla_pkg::CMD_ALLOC, 0, 16384);
		issue(fla_pkg::CMD_ALLOC, 0, 16 * 600);
		free_some_block();
		free_some_block();
		free_some_block();
		issue(fla_pkg::CMD_ALLOC, 0, 255);

		// Random part: mostly allocate/free traffic with the odd donation of
		// fresh units, plus a little noise that the block rejects or ignores.
		for (int n = 0; n < 2000; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				if ($urandom_range(0, 19) == 0)
					issue(fla_pkg::CMD_ALLOC, $urandom_range(0, fla_pkg::HeapUnits - 1),
						$urandom_range(0, 32767));
				else
					issue(fla_pkg::CMD_ALLOC, $urandom_range(0, fla_pkg::HeapUnits - 1),
						$urandom_range(0, 200));
			end else if (pick < 84) begin
				free_some_block();
			end else if (pick < 94) begin
				donate_fresh_region();
			end else if (pick < 96) begin
				issue(fla_pkg::CMD_FREE, $urandom_range(0, 1), $urandom_range(0, 32767));
			end else if (pick < 98) begin
				issue(fla_pkg::CMD_DONATE, 0, $urandom_range(0, 32767));
			end else begin
				issue(fla_pkg::CMD_NONE, $urandom_range(0, fla_pkg::HeapUnits - 1),
					$urandom_range(0, 32767));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request has been taken and answered, then give the
		// block time for one more full walk in case a stray response follows.
		while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);

		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("free_list_heap_allocator verification clean");
		end else begin
			$display("free_list_heap_allocator verification failed");
		end
		$finish;
	end

	// Guard against a hung block: far beyond the slowest correct run.
	initial begin
		#100ms;
		$display("free_list_heap_allocator verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/fla_pkg.sv
rtl/fla_hdr_store.sv
rtl/free_list_heap_allocator.sv
tb/free_list_heap_allocator_test.sv
